@@ design/ptlf_pkg.sv @@
package ptlf_pkg;

  localparam int DATA_WIDTH  = 64;
  localparam int PHASE_WIDTH = 32;
  localparam int GUARD_BITS  = 16;
  localparam int GAIN_WIDTH  = 31;
  localparam int MAX_STAGES  = 32;

  localparam logic [GAIN_WIDTH-1:0] GAIN_Q31 = 31'h4DBA76D4;

  localparam logic [PHASE_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [PHASE_WIDTH-1:0] ATAN_TABLE [0:MAX_STAGES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    QUAD_NONE  = 2'd0,
    QUAD_PLUS  = 2'd1,
    QUAD_MINUS = 2'd2
  } quad_t;

endpackage

@@ design/pose_to_local_frame_core.sv @@
// Expresses a point pose in the frame of a reference pose: the position difference is
// rotated by minus the reference heading through a fully pipelined CORDIC, and the heading
// difference wraps modulo a full turn. One request is taken in every cycle; busy is high only
// during reset. Each result appears on the out_ ports for one cycle with out_valid high,
// after passing one input stage, one quadrant stage, one stage per CORDIC rotation, and six
// stages for gain multiply, rounding and saturation. The receiver cannot stall, so results must be
// captured in the cycle they appear.
module pose_to_local_frame_core #(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_WIDTH     = 16,
  parameter int ROTATION_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [ANGLE_WIDTH-1:0] in_point_theta,
  input  logic signed [COORD_WIDTH-1:0] in_ref_x,
  input  logic signed [COORD_WIDTH-1:0] in_ref_y,
  input  logic signed [ANGLE_WIDTH-1:0] in_ref_theta,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_local_x,
  output logic signed [COORD_WIDTH-1:0] out_local_y,
  output logic signed [ANGLE_WIDTH-1:0] out_local_theta
);
  import ptlf_pkg::*;

  localparam int N           = ROTATION_STAGES;
  localparam int ANGLE_SHIFT = PHASE_WIDTH - ANGLE_WIDTH;
  localparam int PROD_WIDTH  = 32 + GAIN_WIDTH;
  localparam int LRND_WIDTH  = PROD_WIDTH - 30;
  localparam int GAIN_DEPTH  = 6;

  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = (COORD_WIDTH >= DATA_WIDTH) ?
    {1'b0, {(DATA_WIDTH-1){1'b1}}} :
    ((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = -SAT_MAX - 64'sd1;

  logic accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // input stage
  logic                          s0_v_r;
  logic signed [DATA_WIDTH-1:0]  s0_x_r, s0_y_r;
  logic        [PHASE_WIDTH-1:0] s0_z_r;
  logic        [ANGLE_WIDTH-1:0] s0_th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_x_r  <= (DATA_WIDTH'(in_point_x) - DATA_WIDTH'(in_ref_x)) <<< GUARD_BITS;
    s0_y_r  <= (DATA_WIDTH'(in_point_y) - DATA_WIDTH'(in_ref_y)) <<< GUARD_BITS;
    s0_z_r  <= PHASE_WIDTH'(0) -
               (PHASE_WIDTH'($unsigned(in_ref_theta)) << ANGLE_SHIFT);
    s0_th_r <= ANGLE_WIDTH'($unsigned(in_point_theta) - $unsigned(in_ref_theta));
  end

  // quadrant stage and rotation stages
  logic                          cv_r   [0:N];
  logic signed [DATA_WIDTH-1:0]  cx_r   [0:N];
  logic signed [DATA_WIDTH-1:0]  cy_r   [0:N];
  logic        [PHASE_WIDTH-1:0] cz_r   [0:N];
  logic        [ANGLE_WIDTH-1:0] cth_r  [0:N];
  logic signed [DATA_WIDTH-1:0]  cx_nxt [0:N];
  logic signed [DATA_WIDTH-1:0]  cy_nxt [0:N];
  logic        [PHASE_WIDTH-1:0] cz_nxt [0:N];
  quad_t                         quad;

  always_comb begin
    case (s0_z_r[PHASE_WIDTH-1 -: 2])
      2'b01:   quad = QUAD_PLUS;
      2'b10:   quad = QUAD_MINUS;
      default: quad = QUAD_NONE;
    endcase
  end

  always_comb begin
    case (quad)
      QUAD_PLUS: begin
        cx_nxt[0] = -s0_y_r;
        cy_nxt[0] = s0_x_r;
        cz_nxt[0] = s0_z_r - QUARTER_TURN;
      end
      QUAD_MINUS: begin
        cx_nxt[0] = s0_y_r;
        cy_nxt[0] = -s0_x_r;
        cz_nxt[0] = s0_z_r + QUARTER_TURN;
      end
      default: begin
        cx_nxt[0] = s0_x_r;
        cy_nxt[0] = s0_y_r;
        cz_nxt[0] = s0_z_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    cx_r[0]  <= cx_nxt[0];
    cy_r[0]  <= cy_nxt[0];
    cz_r[0]  <= cz_nxt[0];
    cth_r[0] <= s0_th_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_comb begin
      if (!cz_r[i][PHASE_WIDTH-1]) begin
        cx_nxt[i+1] = cx_r[i] - (cy_r[i] >>> i);
        cy_nxt[i+1] = cy_r[i] + (cx_r[i] >>> i);
        cz_nxt[i+1] = cz_r[i] - ATAN_TABLE[i];
      end else begin
        cx_nxt[i+1] = cx_r[i] + (cy_r[i] >>> i);
        cy_nxt[i+1] = cy_r[i] - (cx_r[i] >>> i);
        cz_nxt[i+1] = cz_r[i] + ATAN_TABLE[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      cx_r[i+1]  <= cx_nxt[i+1];
      cy_r[i+1]  <= cy_nxt[i+1];
      cz_r[i+1]  <= cz_nxt[i+1];
      cth_r[i+1] <= cth_r[i];
    end
  end

  // gain, rounding and saturation: lane 0 is x, lane 1 is y
  logic                         gv_r  [0:GAIN_DEPTH-1];
  logic       [ANGLE_WIDTH-1:0] gth_r [0:GAIN_DEPTH-1];
  logic                         neg_r [0:GAIN_DEPTH-2][0:1];

  logic [DATA_WIDTH-1:0]        abs_r  [0:1];
  logic [PROD_WIDTH-1:0]        phi_r  [0:1];
  logic [PROD_WIDTH-1:0]        plo_r  [0:1];
  logic [DATA_WIDTH-1:0]        hi2_r  [0:1];
  logic [LRND_WIDTH-1:0]        lrnd_r [0:1];
  logic [DATA_WIDTH-1:0]        mag_r  [0:1];
  logic [DATA_WIDTH-1:0]        sv_r   [0:1];
  logic signed [COORD_WIDTH-1:0] res_r  [0:1];

  logic signed [DATA_WIDTH-1:0] lane_in  [0:1];
  logic signed [DATA_WIDTH-1:0] rnd_nxt  [0:1];
  logic signed [COORD_WIDTH-1:0] res_nxt [0:1];

  assign lane_in[0] = cx_r[N];
  assign lane_in[1] = cy_r[N];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rnd_nxt[k] = $signed(sv_r[k] + (64'd1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
      if (rnd_nxt[k] > SAT_MAX) begin
        res_nxt[k] = COORD_WIDTH'(SAT_MAX);
      end else if (rnd_nxt[k] < SAT_MIN) begin
        res_nxt[k] = COORD_WIDTH'(SAT_MIN);
      end else begin
        res_nxt[k] = COORD_WIDTH'(rnd_nxt[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < GAIN_DEPTH; s++) begin
        gv_r[s] <= 1'b0;
      end
    end else begin
      gv_r[0] <= cv_r[N];
      for (int s = 1; s < GAIN_DEPTH; s++) begin
        gv_r[s] <= gv_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    gth_r[0] <= cth_r[N];
    for (int s = 1; s < GAIN_DEPTH; s++) begin
      gth_r[s] <= gth_r[s-1];
    end
    for (int k = 0; k < 2; k++) begin
      neg_r[0][k] <= lane_in[k][DATA_WIDTH-1];
      for (int s = 1; s < GAIN_DEPTH - 1; s++) begin
        neg_r[s][k] <= neg_r[s-1][k];
      end
      abs_r[k]  <= lane_in[k][DATA_WIDTH-1] ? DATA_WIDTH'(-lane_in[k]) :
                   DATA_WIDTH'(lane_in[k]);
      phi_r[k]  <= PROD_WIDTH'(abs_r[k][DATA_WIDTH-1:32]) * PROD_WIDTH'(GAIN_Q31);
      plo_r[k]  <= PROD_WIDTH'(abs_r[k][31:0]) * PROD_WIDTH'(GAIN_Q31);
      hi2_r[k]  <= {phi_r[k], 1'b0};
      lrnd_r[k] <= LRND_WIDTH'((DATA_WIDTH'(plo_r[k]) + (64'd1 << 30)) >> 31);
      mag_r[k]  <= hi2_r[k] + DATA_WIDTH'(lrnd_r[k]);
      sv_r[k]   <= neg_r[3][k] ? (64'd0 - mag_r[k]) : mag_r[k];
      res_r[k]  <= res_nxt[k];
    end
  end

  assign out_valid       = gv_r[GAIN_DEPTH-1];
  assign out_local_x     = res_r[0];
  assign out_local_y     = res_r[1];
  assign out_local_theta = $signed(gth_r[GAIN_DEPTH-1]);

endmodule

@@ design/ptlf_checker.sv @@
module ptlf_checker #(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_WIDTH     = 16,
  parameter int ROTATION_STAGES = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] in_point_x,
  input logic signed [COORD_WIDTH-1:0] in_point_y,
  input logic signed [ANGLE_WIDTH-1:0] in_point_theta,
  input logic signed [COORD_WIDTH-1:0] in_ref_x,
  input logic signed [COORD_WIDTH-1:0] in_ref_y,
  input logic signed [ANGLE_WIDTH-1:0] in_ref_theta,
  input logic                          out_valid,
  input logic signed [COORD_WIDTH-1:0] out_local_x,
  input logic signed [COORD_WIDTH-1:0] out_local_y,
  input logic signed [ANGLE_WIDTH-1:0] out_local_theta
);

  localparam int LAT = ROTATION_STAGES + 8;

  logic                   req;
  logic                   same_pos;
  logic [ANGLE_WIDTH-1:0] th_diff;

  assign req      = start && !busy;
  assign same_pos = (in_point_x == in_ref_x) && (in_point_y == in_ref_y);
  assign th_diff  = ANGLE_WIDTH'($unsigned(in_point_theta) - $unsigned(in_ref_theta));

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    req |-> ##LAT out_valid)
    else $error("request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req, LAT))
    else $error("result without request");

  a_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($unsigned(out_local_theta) == $past(th_diff, LAT)))
    else $error("heading difference mismatch");

  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(same_pos, LAT)) |-> (out_local_x == 0 && out_local_y == 0))
    else $error("coincident poses gave nonzero offset");

endmodule

bind pose_to_local_frame_core ptlf_checker #(
  .COORD_WIDTH    (COORD_WIDTH),
  .ANGLE_WIDTH    (ANGLE_WIDTH),
  .ROTATION_STAGES(ROTATION_STAGES)
) u_ptlf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_point_x     (in_point_x),
  .in_point_y     (in_point_y),
  .in_point_theta (in_point_theta),
  .in_ref_x       (in_ref_x),
  .in_ref_y       (in_ref_y),
  .in_ref_theta   (in_ref_theta),
  .out_valid      (out_valid),
  .out_local_x    (out_local_x),
  .out_local_y    (out_local_y),
  .out_local_theta(out_local_theta)
);
